@@ rtl/wav_pcm_stream_decoder_unit_macros.svh @@
// Assertion macros shared by the decoder RTL.
`ifndef WAV_PCM_STREAM_DECODER_UNIT_MACROS_SVH
`define WAV_PCM_STREAM_DECODER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define WPSD_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wpsd: implication check failed");
// Next-cycle implication.
`define WPSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wpsd: next-cycle check failed");
`else
`define WPSD_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define WPSD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/wpsd_pkg.sv @@
// Types and constants of the WAV PCM stream decoder.
`timescale 1ns / 1ps
package wpsd_pkg;

   // result kinds
   localparam logic [2:0] KIND_SAMPLE      = 3'd0;
   localparam logic [2:0] KIND_FORMAT      = 3'd1;
   localparam logic [2:0] KIND_BAD_HEADER  = 3'd2;
   localparam logic [2:0] KIND_UNSUPPORTED = 3'd3;
   localparam logic [2:0] KIND_END         = 3'd4;

   // chunk tags, little-endian as they arrive
   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   localparam logic [31:0] RATE_MIN = 32'd8000;
   localparam logic [31:0] RATE_MAX = 32'd48000;
   localparam logic [31:0] FMT_MIN_SIZE = 32'd16;

   // configuration register
   localparam logic       CSR_IDX_VOLUME = 1'b0;
   localparam logic [6:0] VOLUME_RESET   = 7'd100;

   // divide by 100: q = (x * RECIP_100) >> RECIP_SHIFT, exact for x < 2**22
   localparam int MAG_W       = 16;
   localparam int PROD_W      = 22;
   localparam int RECIP_W     = 23;
   localparam int RECIP_SHIFT = 29;
   localparam logic [RECIP_W-1:0] RECIP_100 = 23'd5368710;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] rate_hz;
      logic [1:0]  channel_count;
      logic [4:0]  sample_width;
      logic        last_of_run;
      logic        then_end;
   } meta_type;

endpackage

@@ rtl/wpsd_if.sv @@
// Request and result channel interfaces of the WAV PCM stream decoder.
`timescale 1ns / 1ps
interface wpsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] file_byte;
   logic       file_start;
   logic       file_end;
   modport source (output valid, file_byte, file_start, file_end, input ready);
   modport sink (input valid, file_byte, file_start, file_end, output ready);
endinterface

interface wpsd_rsp_if;
   logic              valid;
   logic              ready;
   logic [2:0]        result_kind;
   logic signed [15:0] left_sample;
   logic signed [15:0] right_sample;
   logic [15:0]       rate_hz;
   logic [1:0]        channel_count;
   logic [4:0]        sample_width;
   logic              last_of_run;
   modport source (output valid, result_kind, left_sample, right_sample, rate_hz,
                   channel_count, sample_width, last_of_run, input ready);
   modport sink (input valid, result_kind, left_sample, right_sample, rate_hz,
                 channel_count, sample_width, last_of_run, output ready);
endinterface

@@ rtl/wav_pcm_stream_decoder_unit.sv @@
// Top level of the WAV PCM stream decoder: RIFF parser and sample scaler.
// Usage:
//   req_chan carries one file byte per request, with file_start on the first
//   byte of a file and file_end on its last. rsp_chan returns results: format
//   accepted / bad header / unsupported / end markers and scaled stereo pairs.
//   The csr_ port is an APB-style slave with one register, volume_percent at
//   byte address 0; write it only while no request is in flight.
// Pipeline: a request passes the input register, parse, gain multiply,
//   divide by 100 and the output register before its first result shows on
//   rsp_chan.
// Throughput: one request per cycle unless the output stalls. A byte that
//   causes two results (any result followed by the end marker) holds the
//   output register until the end marker is taken, and the pipe behind it fills up.
// Reset: synchronous, active high; clears the parser to idle, empties the
//   pipe and sets the volume to 100.
// Stall: every stage carries its own valid bit and loads when the next stage
//   frees up, so a stalled rsp_chan backs pressure up stage by stage until
//   req_chan.ready drops; nothing is dropped or repeated.
`timescale 1ns / 1ps
`include "wav_pcm_stream_decoder_unit_macros.svh"
module wav_pcm_stream_decoder_unit (
   input  logic              clock,
   input  logic              reset,
   wpsd_req_if.sink          req_chan,
   wpsd_rsp_if.source        rsp_chan,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   // parser phases
   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_RIFF = 3'd1;
   localparam logic [2:0] PH_CHDR = 3'd2;
   localparam logic [2:0] PH_FMT  = 3'd3;
   localparam logic [2:0] PH_SKIP = 3'd4;
   localparam logic [2:0] PH_DATA = 3'd5;
   localparam logic [2:0] PH_DONE = 3'd6;

   localparam int MW = wpsd_pkg::MAG_W;
   localparam int PW = wpsd_pkg::PROD_W;
   localparam int RW = wpsd_pkg::RECIP_W;

   // ---------------------------------------------------------------- config
   logic [6:0] vol_ff;

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vol_ff <= wpsd_pkg::VOLUME_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr[2] == wpsd_pkg::CSR_IDX_VOLUME) begin
         vol_ff <= csr_pwdata[6:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == wpsd_pkg::CSR_IDX_VOLUME) begin
         csr_prdata = {25'd0, vol_ff};
      end
   end

   // ---------------------------------------------------------------- handshake
   logic in_valid_ff, s1_valid_ff, s2_valid_ff, s3_valid_ff, out_valid_ff, out_pend_ff;
   logic in_free, s1_free, s2_free, s3_free, out_free;
   logic fire;

   // The output register frees when it is empty or its result is taken and no
   // end marker waits behind it.
   assign out_free = !out_valid_ff || (rsp_chan.ready && !out_pend_ff);
   assign s3_free  = !s3_valid_ff || out_free;
   assign s2_free  = !s2_valid_ff || s3_free;
   assign s1_free  = !s1_valid_ff || s2_free;
   assign in_free  = !in_valid_ff || fire;
   assign req_chan.ready = in_free;

   // ---------------------------------------------------------------- input register
   logic [7:0] in_byte_ff;
   logic       in_start_ff, in_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_free) begin
         in_valid_ff <= req_chan.valid;
         in_byte_ff  <= req_chan.file_byte;
         in_start_ff <= req_chan.file_start;
         in_end_ff   <= req_chan.file_end;
      end
   end

   // ---------------------------------------------------------------- parser state
   logic [2:0]  phase_ff,  phase_in;
   logic [3:0]  count_ff,  count_in;   // header byte index; pad flag while skipping
   logic [31:0] shift_ff,  shift_in;
   logic [31:0] chunk_ff,  chunk_in;
   logic [15:0] tag_ff,    tag_in;
   logic [15:0] chans_ff,  chans_in;
   logic [15:0] bits_ff,   bits_in;
   logic [31:0] rate_ff,   rate_in;
   logic        seen_ff,   seen_in;
   logic [31:0] remain_ff, remain_in;
   logic [23:0] held_ff,   held_in;
   logic [1:0]  fill_ff,   fill_in;

   logic                 res_valid;
   wpsd_pkg::meta_type   res_meta;
   logic                 res_sign_l, res_sign_r;
   logic [MW-1:0]        res_mag_l, res_mag_r;

   always_comb begin
      logic        active;
      logic [31:0] word;
      logic [31:0] frame;
      logic [31:0] skip_len;
      logic        skip_pad;
      logic        frame_done;
      logic        fmt_ok;
      logic [15:0] samp_l, samp_r;

      phase_in  = phase_ff;
      count_in  = count_ff;
      shift_in  = shift_ff;
      chunk_in  = chunk_ff;
      tag_in    = tag_ff;
      chans_in  = chans_ff;
      bits_in   = bits_ff;
      rate_in   = rate_ff;
      seen_in   = seen_ff;
      remain_in = remain_ff;
      held_in   = held_ff;
      fill_in   = fill_ff;

      res_valid  = 1'b0;
      res_meta   = '0;
      res_sign_l = 1'b0;
      res_sign_r = 1'b0;
      res_mag_l  = '0;
      res_mag_r  = '0;

      word       = '0;
      frame      = '0;
      skip_len   = '0;
      skip_pad   = 1'b0;
      frame_done = 1'b0;
      fmt_ok     = 1'b0;
      samp_l     = '0;
      samp_r     = '0;

      // restart on file_start whatever the phase
      if (in_start_ff) begin
         phase_in  = PH_RIFF;
         count_in  = '0;
         shift_in  = '0;
         chunk_in  = '0;
         tag_in    = '0;
         chans_in  = '0;
         bits_in   = '0;
         rate_in   = '0;
         seen_in   = 1'b0;
         remain_in = '0;
         held_in   = '0;
         fill_in   = '0;
      end

      active = (phase_in != PH_IDLE);

      if (active) begin
         word     = {in_byte_ff, shift_in[31:8]};
         shift_in = word;

         case (phase_in)
            PH_RIFF: begin
               if (count_in == 4'd3 && word != wpsd_pkg::TAG_RIFF) begin
                  res_valid     = 1'b1;
                  res_meta.kind = wpsd_pkg::KIND_BAD_HEADER;
                  phase_in      = PH_DONE;
               end else if (count_in == 4'd11) begin
                  if (word != wpsd_pkg::TAG_WAVE) begin
                     res_valid     = 1'b1;
                     res_meta.kind = wpsd_pkg::KIND_BAD_HEADER;
                     phase_in      = PH_DONE;
                  end else begin
                     phase_in = PH_CHDR;
                     count_in = '0;
                  end
               end else begin
                  count_in = count_in + 4'd1;
               end
            end
            PH_CHDR: begin
               if (count_in == 4'd3) begin
                  chunk_in = word;
                  count_in = count_in + 4'd1;
               end else if (count_in == 4'd7) begin
                  count_in = '0;
                  if (chunk_in == wpsd_pkg::TAG_FMT) begin
                     if (word < wpsd_pkg::FMT_MIN_SIZE) begin
                        res_valid     = 1'b1;
                        res_meta.kind = wpsd_pkg::KIND_BAD_HEADER;
                        phase_in      = PH_DONE;
                     end else begin
                        chunk_in = word;
                        phase_in = PH_FMT;
                     end
                  end else if (chunk_in == wpsd_pkg::TAG_DATA && seen_ff) begin
                     remain_in = word;
                     fmt_ok = (tag_in == 16'd1) &&
                              (chans_in == 16'd1 || chans_in == 16'd2) &&
                              (bits_in == 16'd8 || bits_in == 16'd16) &&
                              (rate_in >= wpsd_pkg::RATE_MIN) &&
                              (rate_in <= wpsd_pkg::RATE_MAX);
                     res_valid = 1'b1;
                     if (fmt_ok) begin
                        res_meta.kind          = wpsd_pkg::KIND_FORMAT;
                        res_meta.rate_hz       = rate_in[15:0];
                        res_meta.channel_count = chans_in[1:0];
                        res_meta.sample_width  = bits_in[4:0];
                        phase_in               = PH_DATA;
                     end else begin
                        res_meta.kind = wpsd_pkg::KIND_UNSUPPORTED;
                        phase_in      = PH_DONE;
                     end
                  end else begin
                     skip_len = word;
                     skip_pad = word[0];
                     chunk_in = skip_len;
                     count_in = {3'd0, skip_pad};
                     if (skip_len == '0 && !skip_pad) begin
                        phase_in = PH_CHDR;
                     end else begin
                        phase_in = PH_SKIP;
                     end
                  end
               end else begin
                  count_in = count_in + 4'd1;
               end
            end
            PH_FMT: begin
               if (count_in == 4'd1) tag_in = word[31:16];
               if (count_in == 4'd3) chans_in = word[31:16];
               if (count_in == 4'd7) rate_in = word;
               if (count_in == 4'd15) begin
                  bits_in  = word[31:16];
                  seen_in  = 1'b1;
                  // skip what is left of the fmt chunk, plus its pad byte
                  skip_len = chunk_in - wpsd_pkg::FMT_MIN_SIZE;
                  skip_pad = chunk_in[0];
                  chunk_in = skip_len;
                  count_in = {3'd0, skip_pad};
                  if (skip_len == '0 && !skip_pad) begin
                     phase_in = PH_CHDR;
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end else begin
                  count_in = count_in + 4'd1;
               end
            end
            PH_SKIP: begin
               if (chunk_in != '0) begin
                  chunk_in = chunk_in - 32'd1;
               end else begin
                  count_in = '0;
               end
               if (chunk_in == '0 && count_in == '0) begin
                  phase_in = PH_CHDR;
               end
            end
            PH_DATA: begin
               if (remain_in != '0) begin
                  remain_in = remain_in - 32'd1;
                  frame = {8'd0, held_in} | ({24'd0, in_byte_ff} << {fill_in, 3'b000});
                  // frame length 1, 2 or 4 bytes
                  if (bits_in[3] && chans_in[0]) begin
                     frame_done = 1'b1;
                  end else if (bits_in[3] || chans_in[0]) begin
                     frame_done = (fill_in != 2'd0);
                  end else begin
                     frame_done = (fill_in == 2'd3);
                  end
                  if (frame_done) begin
                     if (bits_in[3]) begin
                        samp_l = {~frame[7], frame[6:0], 8'h00};
                        samp_r = {~frame[15], frame[14:8], 8'h00};
                     end else begin
                        samp_l = frame[15:0];
                        samp_r = frame[31:16];
                     end
                     if (chans_in[0]) begin
                        samp_r = samp_l;
                     end
                     res_valid     = 1'b1;
                     res_meta.kind = wpsd_pkg::KIND_SAMPLE;
                     res_sign_l    = samp_l[15];
                     res_sign_r    = samp_r[15];
                     res_mag_l     = samp_l[15] ? (~samp_l + 16'd1) : samp_l;
                     res_mag_r     = samp_r[15] ? (~samp_r + 16'd1) : samp_r;
                     held_in       = '0;
                     fill_in       = '0;
                  end else begin
                     held_in = frame[23:0];
                     fill_in = fill_in + 2'd1;
                  end
               end
            end
            default: begin
            end
         endcase

         // end of file: close out with the end marker, after a bad-header
         // result when the header never completed
         if (in_end_ff) begin
            if (res_valid) begin
               res_meta.then_end = 1'b1;
            end else if (phase_in inside {[PH_RIFF:PH_SKIP]}) begin
               res_valid         = 1'b1;
               res_meta.kind     = wpsd_pkg::KIND_BAD_HEADER;
               res_meta.then_end = 1'b1;
            end else begin
               res_valid     = 1'b1;
               res_meta.kind = wpsd_pkg::KIND_END;
            end
            phase_in  = PH_IDLE;
            count_in  = '0;
            shift_in  = '0;
            chunk_in  = '0;
            tag_in    = '0;
            chans_in  = '0;
            bits_in   = '0;
            rate_in   = '0;
            seen_in   = 1'b0;
            remain_in = '0;
            held_in   = '0;
            fill_in   = '0;
         end
         res_meta.last_of_run = !res_meta.then_end;
      end
   end

   // A byte with no result never waits for the pipe.
   assign fire = in_valid_ff && (!res_valid || s1_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         count_ff  <= '0;
         shift_ff  <= '0;
         chunk_ff  <= '0;
         tag_ff    <= '0;
         chans_ff  <= '0;
         bits_ff   <= '0;
         rate_ff   <= '0;
         seen_ff   <= 1'b0;
         remain_ff <= '0;
         held_ff   <= '0;
         fill_ff   <= '0;
      end else if (fire) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         shift_ff  <= shift_in;
         chunk_ff  <= chunk_in;
         tag_ff    <= tag_in;
         chans_ff  <= chans_in;
         bits_ff   <= bits_in;
         rate_ff   <= rate_in;
         seen_ff   <= seen_in;
         remain_ff <= remain_in;
         held_ff   <= held_in;
         fill_ff   <= fill_in;
      end
   end

   // ---------------------------------------------------------------- stage 1: parsed result
   wpsd_pkg::meta_type s1_meta_ff;
   logic               s1_sign_l_ff, s1_sign_r_ff;
   logic [MW-1:0]      s1_mag_l_ff, s1_mag_r_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff  <= fire && res_valid;
         s1_meta_ff   <= res_meta;
         s1_sign_l_ff <= res_sign_l;
         s1_sign_r_ff <= res_sign_r;
         s1_mag_l_ff  <= res_mag_l;
         s1_mag_r_ff  <= res_mag_r;
      end
   end

   // ---------------------------------------------------------------- stage 2: gain multiply
   wpsd_pkg::meta_type s2_meta_ff;
   logic               s2_sign_l_ff, s2_sign_r_ff;
   logic [PW-1:0]      s2_prod_l_ff, s2_prod_r_ff;
   logic [MW+6:0]      gain_l, gain_r;

   assign gain_l = {7'd0, s1_mag_l_ff} * {{MW{1'b0}}, vol_ff};
   assign gain_r = {7'd0, s1_mag_r_ff} * {{MW{1'b0}}, vol_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff  <= s1_valid_ff;
         s2_meta_ff   <= s1_meta_ff;
         s2_sign_l_ff <= s1_sign_l_ff;
         s2_sign_r_ff <= s1_sign_r_ff;
         s2_prod_l_ff <= gain_l[PW-1:0];
         s2_prod_r_ff <= gain_r[PW-1:0];
      end
   end

   // ---------------------------------------------------------------- stage 3: divide by 100
   wpsd_pkg::meta_type s3_meta_ff;
   logic               s3_sign_l_ff, s3_sign_r_ff;
   logic [MW-1:0]      s3_quo_l_ff, s3_quo_r_ff;
   logic [PW+RW-1:0]   recip_l, recip_r;

   assign recip_l = {{RW{1'b0}}, s2_prod_l_ff} * {{PW{1'b0}}, wpsd_pkg::RECIP_100};
   assign recip_r = {{RW{1'b0}}, s2_prod_r_ff} * {{PW{1'b0}}, wpsd_pkg::RECIP_100};

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_free) begin
         s3_valid_ff  <= s2_valid_ff;
         s3_meta_ff   <= s2_meta_ff;
         s3_sign_l_ff <= s2_sign_l_ff;
         s3_sign_r_ff <= s2_sign_r_ff;
         s3_quo_l_ff  <= recip_l[wpsd_pkg::RECIP_SHIFT +: MW];
         s3_quo_r_ff  <= recip_r[wpsd_pkg::RECIP_SHIFT +: MW];
      end
   end

   // ---------------------------------------------------------------- output register
   logic [15:0] sat_l, sat_r;

   // restore sign and saturate to the 16-bit range
   always_comb begin
      if (s3_sign_l_ff) begin
         sat_l = (s3_quo_l_ff > 16'h8000) ? 16'h8000 : (~s3_quo_l_ff + 16'd1);
      end else begin
         sat_l = (s3_quo_l_ff > 16'h7FFF) ? 16'h7FFF : s3_quo_l_ff;
      end
      if (s3_sign_r_ff) begin
         sat_r = (s3_quo_r_ff > 16'h8000) ? 16'h8000 : (~s3_quo_r_ff + 16'd1);
      end else begin
         sat_r = (s3_quo_r_ff > 16'h7FFF) ? 16'h7FFF : s3_quo_r_ff;
      end
   end

   logic [2:0]  out_kind_ff;
   logic [15:0] out_left_ff, out_right_ff, out_rate_ff;
   logic [1:0]  out_chans_ff;
   logic [4:0]  out_width_ff;
   logic        out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         out_pend_ff  <= 1'b0;
      end else if (out_valid_ff && out_pend_ff && rsp_chan.ready) begin
         // first result taken: advance to the end marker of the same byte
         out_pend_ff  <= 1'b0;
         out_kind_ff  <= wpsd_pkg::KIND_END;
         out_left_ff  <= '0;
         out_right_ff <= '0;
         out_rate_ff  <= '0;
         out_chans_ff <= '0;
         out_width_ff <= '0;
         out_last_ff  <= 1'b1;
      end else if (out_free) begin
         out_valid_ff <= s3_valid_ff;
         out_pend_ff  <= s3_valid_ff && s3_meta_ff.then_end;
         out_kind_ff  <= s3_meta_ff.kind;
         out_left_ff  <= sat_l;
         out_right_ff <= sat_r;
         out_rate_ff  <= s3_meta_ff.rate_hz;
         out_chans_ff <= s3_meta_ff.channel_count;
         out_width_ff <= s3_meta_ff.sample_width;
         out_last_ff  <= s3_meta_ff.last_of_run;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.result_kind   = out_kind_ff;
   assign rsp_chan.left_sample   = out_left_ff;
   assign rsp_chan.right_sample  = out_right_ff;
   assign rsp_chan.rate_hz       = out_rate_ff;
   assign rsp_chan.channel_count = out_chans_ff;
   assign rsp_chan.sample_width  = out_width_ff;
   assign rsp_chan.last_of_run   = out_last_ff;

   // ---------------------------------------------------------------- assertions
   `WPSD_ASSERT_IMPLIES(a_pend_holds_first, clock, reset, out_pend_ff, out_valid_ff && out_kind_ff != wpsd_pkg::KIND_END && !out_last_ff)
   `WPSD_ASSERT_NEXT(a_end_follows, clock, reset, out_valid_ff && out_pend_ff && rsp_chan.ready, out_valid_ff && out_kind_ff == wpsd_pkg::KIND_END && out_last_ff)
   `WPSD_ASSERT_IMPLIES(a_sample_in_data, clock, reset, fire && res_valid && res_meta.kind == wpsd_pkg::KIND_SAMPLE, phase_ff == PH_DATA && !in_start_ff)

endmodule
